// File: hdl/cash_pkg.sv
// Shared types, widths, register indexes and the arctangent table for the
// compass adjust / slew / heading block. No dependencies.
`default_nettype none
package cash_pkg;

   localparam int RAW_W  = 16;
   localparam int ASA_W  = 8;
   localparam int PROD_W = 25;   // raw * (asa + 128), Q8
   localparam int FILT_W = 25;
   localparam int HEAD_W = 15;
   localparam int CNT_W  = 8;
   localparam int IDX_W  = 2;
   localparam int CW     = 44;   // CORDIC x/y datapath
   localparam int ZW     = 27;   // CORDIC angle, degrees Q16

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 8;

   localparam logic [ASA_W-1:0] ASA_RESET    = 8'd128;
   localparam logic [CNT_W-1:0] WARMUP_RESET = 8'd5;

   localparam logic [IDX_W-1:0] REG_ASA_X  = 2'd0;
   localparam logic [IDX_W-1:0] REG_ASA_Y  = 2'd1;
   localparam logic [IDX_W-1:0] REG_ASA_Z  = 2'd2;
   localparam logic [IDX_W-1:0] REG_WARMUP = 2'd3;

   localparam logic signed [ZW-1:0]     ANG_90   = 27'sd5898240;
   localparam logic signed [HEAD_W:0]   HEAD_MAX = 16'sd11520;
   localparam logic signed [ZW:0]       HEAD_RND = 28'sd512;

   typedef struct packed {
      logic signed [PROD_W-1:0] px;
      logic signed [PROD_W-1:0] py;
      logic signed [PROD_W-1:0] pz;
   } item_type;

   typedef struct packed {
      logic signed [FILT_W-1:0] fx;
      logic signed [FILT_W-1:0] fy;
      logic signed [FILT_W-1:0] fz;
      logic [2:0]               mask;
      logic                     zero;
   } side_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic signed [ZW-1:0] atan_deg(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0: r = 27'sd2949120;   1: r = 27'sd1740967;   2: r = 27'sd919879;
         3: r = 27'sd466945;    4: r = 27'sd234379;    5: r = 27'sd117304;
         6: r = 27'sd58666;     7: r = 27'sd29335;     8: r = 27'sd14668;
         9: r = 27'sd7334;     10: r = 27'sd3667;     11: r = 27'sd1833;
        12: r = 27'sd917;      13: r = 27'sd458;      14: r = 27'sd229;
        15: r = 27'sd115;      16: r = 27'sd57;       17: r = 27'sd29;
        18: r = 27'sd14;       19: r = 27'sd7;        20: r = 27'sd4;
        21: r = 27'sd2;        22: r = 27'sd1;
        default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hdl/cash_front.sv
// Front end: sensitivity scaling of the raw sample and a two-entry queue
// toward the back end. Depends on cash_pkg.
`default_nettype none
module cash_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic signed [cash_pkg::RAW_W-1:0]   req_raw_x,
   input  wire logic signed [cash_pkg::RAW_W-1:0]   req_raw_y,
   input  wire logic signed [cash_pkg::RAW_W-1:0]   req_raw_z,
   input  wire logic [cash_pkg::ASA_W-1:0]          asa_x,
   input  wire logic [cash_pkg::ASA_W-1:0]          asa_y,
   input  wire logic [cash_pkg::ASA_W-1:0]          asa_z,
   input  wire logic                                pop,
   output      logic                                q_valid,
   output      cash_pkg::item_type                  q_item
);
   cash_pkg::item_type q_mem [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cash_pkg::item_type item;

   function automatic logic signed [cash_pkg::PROD_W-1:0] scale(
      input logic signed [cash_pkg::RAW_W-1:0] raw, input logic [cash_pkg::ASA_W-1:0] asa);
      logic signed [cash_pkg::ASA_W+1:0] g;
      g = $signed({2'b00, asa}) + 10'sd128;
      return cash_pkg::PROD_W'(raw * g);
   endfunction

   assign item.px = scale(req_raw_x, asa_x);
   assign item.py = scale(req_raw_y, asa_y);
   assign item.pz = scale(req_raw_z, asa_z);

   assign req_stall = cnt_ff[1];
   assign push      = req_valid && !cnt_ff[1];
   assign q_valid   = cnt_ff != 2'd0;
   assign q_item    = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (pop && q_valid) ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= item;
      end
   end
endmodule
`default_nettype wire

// File: hdl/cash_slew.sv
// Back end stage one: Q format conversion, warm-up count, per-axis slew
// limit and CORDIC pre-rotation. Depends on cash_pkg.
`default_nettype none
module cash_slew #(
   parameter int FRAC_BITS = cash_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              q_valid,
   input  wire cash_pkg::item_type                q_item,
   input  wire logic [cash_pkg::CNT_W-1:0]        warmup_samples,
   output      logic                              s_valid_ff,
   output      logic signed [cash_pkg::CW-1:0]    s_a_ff,
   output      logic signed [cash_pkg::CW-1:0]    s_b_ff,
   output      logic signed [cash_pkg::ZW-1:0]    s_z_ff,
   output      cash_pkg::side_type                s_side_ff
);
   localparam int AW = 17 + FRAC_BITS;
   localparam int SH = AW + 4;
   localparam longint unsigned DIV_L = ((64'd1 << SH) + 64'd9) / 64'd10;
   localparam logic [AW:0] DIV_M = DIV_L[AW:0];

   logic signed [AW-1:0] last_ff [3];
   logic signed [AW-1:0] last_in [3];
   logic [2:0]           hit;
   logic [cash_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic active, take;
   logic signed [cash_pkg::PROD_W-1:0] prod [3];

   logic signed [cash_pkg::CW-1:0] a0, b0, a_in, b_in;
   logic signed [cash_pkg::ZW-1:0] z_in;
   cash_pkg::side_type side_in;

   assign prod[0] = q_item.px;
   assign prod[1] = q_item.py;
   assign prod[2] = q_item.pz;
   assign take    = en && q_valid;
   assign active  = cnt_ff >= warmup_samples;

   always_comb begin
      logic signed [AW+7:0]  ext;
      logic signed [AW-1:0]  adj;
      logic [AW-1:0]         mag;
      logic [2*AW:0]         qm;
      logic signed [AW:0]    d, up, lo, adj_e;
      for (int k = 0; k < 3; k++) begin
         ext   = (AW+8)'(prod[k]);
         ext   = ext <<< FRAC_BITS;
         adj   = ext[AW+7:8];
         mag   = last_ff[k][AW-1] ? AW'(-last_ff[k]) : AW'(last_ff[k]);
         qm    = (2*AW+1)'(mag) * (2*AW+1)'(DIV_M);
         d     = $signed({1'b0, AW'(qm >> SH)});
         up    = (AW+1)'(last_ff[k]) + d;
         lo    = (AW+1)'(last_ff[k]) - d;
         adj_e = (AW+1)'(adj);
         hit[k]     = 1'b0;
         last_in[k] = adj;
         if (active && adj_e > up) begin
            last_in[k] = up[AW-1:0];
            hit[k]     = 1'b1;
         end else if (active && adj_e < lo) begin
            last_in[k] = lo[AW-1:0];
            hit[k]     = 1'b1;
         end
      end
      cnt_in = active ? cnt_ff : cnt_ff + 1'b1;
   end

   // heading CORDIC start vector, rotated into the right half plane
   always_comb begin
      a0 = cash_pkg::CW'(q_item.py) <<< 16;
      b0 = cash_pkg::CW'(q_item.px) <<< 16;
      a_in = a0;
      b_in = b0;
      z_in = '0;
      if (a0 < 0) begin
         if (b0 >= 0) begin
            a_in = b0;
            b_in = -a0;
            z_in = cash_pkg::ANG_90;
         end else begin
            a_in = -b0;
            b_in = a0;
            z_in = -cash_pkg::ANG_90;
         end
      end
      side_in.fx   = cash_pkg::FILT_W'(last_in[0]);
      side_in.fy   = cash_pkg::FILT_W'(last_in[1]);
      side_in.fz   = cash_pkg::FILT_W'(last_in[2]);
      side_in.mask = hit;
      side_in.zero = (q_item.px == '0) && (q_item.py == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         cnt_ff     <= '0;
         for (int k = 0; k < 3; k++) last_ff[k] <= '0;
      end else begin
         if (en) s_valid_ff <= q_valid;
         if (take) begin
            cnt_ff <= cnt_in;
            for (int k = 0; k < 3; k++) last_ff[k] <= last_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_a_ff    <= a_in;
         s_b_ff    <= b_in;
         s_z_ff    <= z_in;
         s_side_ff <= side_in;
      end
   end

`ifndef SYNTHESIS
   a_no_limit_in_warmup: assert property (@(posedge clock) disable iff (reset)
      (take && !active) |-> (hit == 3'b000))
      else $error("axis clamped during warm-up");
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> cnt_ff >= $past(cnt_ff))
      else $error("warm-up count went backward");
   a_zero_sticks: assert property (@(posedge clock) disable iff (reset)
      (take && active && last_ff[0] == '0) |-> (last_in[0] == '0))
      else $error("x axis left zero after warm-up");
`endif
endmodule
`default_nettype wire

// File: hdl/cash_cordic.sv
// Back end: vectoring CORDIC pipeline, heading rounding and saturation, and
// the result register. Depends on cash_pkg.
`default_nettype none
module cash_cordic #(
   parameter int CORDIC_STEPS = cash_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 s_valid,
   input  wire logic signed [cash_pkg::CW-1:0]       s_a,
   input  wire logic signed [cash_pkg::CW-1:0]       s_b,
   input  wire logic signed [cash_pkg::ZW-1:0]       s_z,
   input  wire cash_pkg::side_type                   s_side,
   output      logic                                 rsp_valid,
   output      logic signed [cash_pkg::FILT_W-1:0]   rsp_filt_x,
   output      logic signed [cash_pkg::FILT_W-1:0]   rsp_filt_y,
   output      logic signed [cash_pkg::FILT_W-1:0]   rsp_filt_z,
   output      logic signed [cash_pkg::HEAD_W-1:0]   rsp_heading,
   output      logic [2:0]                           rsp_limited_mask
);
   logic signed [cash_pkg::CW-1:0] a_ff [CORDIC_STEPS+1];
   logic signed [cash_pkg::CW-1:0] b_ff [CORDIC_STEPS+1];
   logic signed [cash_pkg::ZW-1:0] z_ff [CORDIC_STEPS+1];
   cash_pkg::side_type             side_ff [CORDIC_STEPS+1];
   logic [CORDIC_STEPS:0]          v_ff;

   assign a_ff[0]    = s_a;
   assign b_ff[0]    = s_b;
   assign z_ff[0]    = s_z;
   assign side_ff[0] = s_side;
   assign v_ff[0]    = s_valid;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [cash_pkg::CW-1:0] da, db;
      assign da = b_ff[i] >>> i;
      assign db = a_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i+1] <= side_ff[i];
            if (b_ff[i] >= 0) begin
               a_ff[i+1] <= a_ff[i] + da;
               b_ff[i+1] <= b_ff[i] - db;
               z_ff[i+1] <= z_ff[i] + cash_pkg::atan_deg(i);
            end else begin
               a_ff[i+1] <= a_ff[i] - da;
               b_ff[i+1] <= b_ff[i] + db;
               z_ff[i+1] <= z_ff[i] - cash_pkg::atan_deg(i);
            end
         end
      end
   end

   logic signed [cash_pkg::ZW:0]     zr;
   logic signed [cash_pkg::ZW-10:0]  hq;
   logic signed [cash_pkg::HEAD_W-1:0] head_in;
   cash_pkg::side_type               so;

   assign so = side_ff[CORDIC_STEPS];

   always_comb begin
      zr = cash_pkg::HEAD_RND - (cash_pkg::ZW+1)'(z_ff[CORDIC_STEPS]);
      hq = zr[cash_pkg::ZW:10];
      if (so.zero) begin
         head_in = '0;
      end else if (hq > (cash_pkg::ZW-9)'(cash_pkg::HEAD_MAX)) begin
         head_in = cash_pkg::HEAD_W'(cash_pkg::HEAD_MAX);
      end else if (hq < -(cash_pkg::ZW-9)'(cash_pkg::HEAD_MAX)) begin
         head_in = -cash_pkg::HEAD_W'(cash_pkg::HEAD_MAX);
      end else begin
         head_in = cash_pkg::HEAD_W'(hq);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (en) begin
         rsp_valid <= v_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_filt_x       <= so.fx;
         rsp_filt_y       <= so.fy;
         rsp_filt_z       <= so.fz;
         rsp_limited_mask <= so.mask;
         rsp_heading      <= head_in;
      end
   end
endmodule
`default_nettype wire

// File: hdl/compass_adjust_slew_heading_top.sv
// Path: a request transfer is written into the queue, then registered in the
// slew stage, in one register per CORDIC step and in the result register.
// Throughput: one item per cycle while the result is not stalled; the slew
// recurrence is combinational and the CORDIC is fully pipelined. A result
// stall freezes the back end; the two-entry queue takes items until full.
// Reset: synchronous; clears queue count, valids and slew state; presets CSRs.
`default_nettype none
module compass_adjust_slew_heading_top #(
   parameter int CORDIC_STEPS = cash_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = cash_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic signed [cash_pkg::RAW_W-1:0]   req_raw_x,
   input  wire logic signed [cash_pkg::RAW_W-1:0]   req_raw_y,
   input  wire logic signed [cash_pkg::RAW_W-1:0]   req_raw_z,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic signed [cash_pkg::FILT_W-1:0]  rsp_filt_x,
   output      logic signed [cash_pkg::FILT_W-1:0]  rsp_filt_y,
   output      logic signed [cash_pkg::FILT_W-1:0]  rsp_filt_z,
   output      logic signed [cash_pkg::HEAD_W-1:0]  rsp_heading,
   output      logic [2:0]                          rsp_limited_mask,
   input  wire logic                                csr_we,
   input  wire logic [cash_pkg::IDX_W-1:0]          csr_index,
   input  wire logic [cash_pkg::ASA_W-1:0]          csr_wdata
);
   logic [cash_pkg::ASA_W-1:0] asa_x_ff, asa_y_ff, asa_z_ff;
   logic [cash_pkg::CNT_W-1:0] warmup_ff;
   logic en, q_valid, s_valid;
   cash_pkg::item_type q_item;
   logic signed [cash_pkg::CW-1:0] s_a, s_b;
   logic signed [cash_pkg::ZW-1:0] s_z;
   cash_pkg::side_type s_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         asa_x_ff  <= cash_pkg::ASA_RESET;
         asa_y_ff  <= cash_pkg::ASA_RESET;
         asa_z_ff  <= cash_pkg::ASA_RESET;
         warmup_ff <= cash_pkg::WARMUP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cash_pkg::REG_ASA_X:  asa_x_ff  <= csr_wdata;
            cash_pkg::REG_ASA_Y:  asa_y_ff  <= csr_wdata;
            cash_pkg::REG_ASA_Z:  asa_z_ff  <= csr_wdata;
            cash_pkg::REG_WARMUP: warmup_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // back end advances whenever the result register is free or being taken
   assign en = !rsp_valid || !rsp_stall;

   cash_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_raw_x, .req_raw_y, .req_raw_z,
      .asa_x(asa_x_ff), .asa_y(asa_y_ff), .asa_z(asa_z_ff),
      .pop(en), .q_valid, .q_item
   );

   cash_slew #(.FRAC_BITS(FRAC_BITS)) u_slew (
      .clock, .reset, .en, .q_valid, .q_item, .warmup_samples(warmup_ff),
      .s_valid_ff(s_valid), .s_a_ff(s_a), .s_b_ff(s_b), .s_z_ff(s_z),
      .s_side_ff(s_side)
   );

   cash_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset, .en, .s_valid, .s_a, .s_b, .s_z, .s_side,
      .rsp_valid, .rsp_filt_x, .rsp_filt_y, .rsp_filt_z, .rsp_heading,
      .rsp_limited_mask
   );
endmodule
`default_nettype wire
